// ----- rtl/core/ps2_mouse_packet_tracker_core_macros.svh -----
// Assertion macros for the mouse packet tracker core.
// Included by modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define PMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ps2mpt_pkg.sv -----
// Shared types and constants for the mouse packet tracker core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ps2mpt_pkg;

  localparam int SyncBit   = 3;
  localparam int BtnW      = 3;
  localparam int ByteW     = 8;
  localparam int DeltaW    = 9;
  localparam int LeftBit   = 0;
  localparam int RightBit  = 1;

  typedef logic [8:0] pos_x_t;
  typedef logic [7:0] pos_y_t;

  typedef enum logic [2:0] {
    PH_HEAD  = 3'b001,
    PH_XMOVE = 3'b010,
    PH_YMOVE = 3'b100
  } phase_e;

endpackage

`default_nettype wire

// ----- rtl/core/ps2mpt_clamp.sv -----
// One cursor axis: add a signed movement and saturate to 0..SIZE-1.
// Depends on ps2mpt_pkg for the movement width.
`timescale 1ns / 1ps
`default_nettype none

module ps2mpt_clamp import ps2mpt_pkg::*; #(
  parameter int SIZE = 320,
  parameter int CW   = $clog2(SIZE)
) (
  input  logic [CW-1:0]            cur_i,
  input  logic signed [DeltaW-1:0] delta_i,
  output logic [CW-1:0]            next_o
);

  localparam int SW = ((CW > DeltaW) ? CW : DeltaW) + 2;
  localparam logic signed [SW-1:0] SizeS = SW'(SIZE);
  localparam logic [CW-1:0] MaxPos = CW'(SIZE - 1);

  logic signed [SW-1:0] sum;

  always_comb begin
    sum = $signed({{(SW-CW){1'b0}}, cur_i})
        + $signed({{(SW-DeltaW){delta_i[DeltaW-1]}}, delta_i});
    if (sum < 0) begin
      next_o = '0;
    end else if (sum >= SizeS) begin
      next_o = MaxPos;
    end else begin
      next_o = sum[CW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ps2_mouse_packet_tracker_core.sv -----
// Mouse packet tracker: frames bytes into three-byte packets, moves a clamped cursor.
// Bytes pass an input register, then one pass of logic into the result register.
// Throughput: one byte per cycle while res_ready_i does not stall the held result.
// Reset: framing at byte one, buttons and stored X movement zero, cursor at screen center,
// no request in flight. Depends on ps2mpt_pkg, ps2mpt_clamp and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "ps2_mouse_packet_tracker_core_macros.svh"

module ps2_mouse_packet_tracker_core import ps2mpt_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rx_valid_i,
  output logic                    rx_ready_o,
  input  logic [7:0]              rx_byte_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [8:0]              pos_x_o,
  output logic [7:0]              pos_y_o,
  output logic signed [7:0]       delta_x_o,
  output logic signed [8:0]       delta_y_o,
  output logic [2:0]              button_bits_o,
  output logic                    left_click_o,
  output logic                    right_click_o
);

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam logic [XW-1:0] XReset = XW'(SCREEN_WIDTH / 2);
  localparam logic [YW-1:0] YReset = YW'(SCREEN_HEIGHT / 2);
  localparam logic [XW-1:0] XMax   = XW'(SCREEN_WIDTH - 1);
  localparam logic [YW-1:0] YMax   = YW'(SCREEN_HEIGHT - 1);

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  phase_e           phase_q, phase_d;
  logic [BtnW-1:0]  header_btn_q, header_btn_d;
  logic [ByteW-1:0] x_move_q, x_move_d;
  logic [XW-1:0]    cursor_x_q, cursor_x_d, cursor_x_next;
  logic [YW-1:0]    cursor_y_q, cursor_y_d, cursor_y_next;
  logic [BtnW-1:0]  held_q, held_d;
  logic             out_valid_q, out_valid_d;

  logic               in_fire, s1_fire, out_free, emit;
  logic signed [DeltaW-1:0] dx_wide, dy;

  assign out_free   = !out_valid_q || res_ready_i;
  assign rx_ready_o = !s1_valid_q || out_free;
  assign in_fire    = rx_valid_i && rx_ready_o;
  assign s1_fire    = s1_valid_q && out_free;

  assign dx_wide = $signed({x_move_q[ByteW-1], x_move_q});
  assign dy      = -$signed({s1_byte_q[ByteW-1], s1_byte_q});

  ps2mpt_clamp #(.SIZE(SCREEN_WIDTH), .CW(XW)) u_clamp_x (
    .cur_i   (cursor_x_q),
    .delta_i (dx_wide),
    .next_o  (cursor_x_next)
  );

  ps2mpt_clamp #(.SIZE(SCREEN_HEIGHT), .CW(YW)) u_clamp_y (
    .cur_i   (cursor_y_q),
    .delta_i (dy),
    .next_o  (cursor_y_next)
  );

  always_comb begin
    phase_d      = phase_q;
    header_btn_d = header_btn_q;
    x_move_d     = x_move_q;
    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    held_d       = held_q;
    emit         = 1'b0;
    if (s1_fire) begin
      case (phase_q)
        PH_XMOVE: begin
          x_move_d = s1_byte_q;
          phase_d  = PH_YMOVE;
        end
        PH_YMOVE: begin
          phase_d    = PH_HEAD;
          held_d     = header_btn_q;
          cursor_x_d = cursor_x_next;
          cursor_y_d = cursor_y_next;
          emit       = 1'b1;
        end
        default: begin
          if (s1_byte_q[SyncBit]) begin
            header_btn_d = s1_byte_q[BtnW-1:0];
            phase_d      = PH_XMOVE;
          end else begin
            phase_d = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_HEAD;
      header_btn_q <= '0;
      x_move_q     <= '0;
      cursor_x_q   <= XReset;
      cursor_y_q   <= YReset;
      held_q       <= '0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      phase_q      <= phase_d;
      header_btn_q <= header_btn_d;
      x_move_q     <= x_move_d;
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      held_q       <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_fire && emit) begin
      pos_x_o       <= pos_x_t'(cursor_x_next);
      pos_y_o       <= pos_y_t'(cursor_y_next);
      delta_x_o     <= $signed(x_move_q);
      delta_y_o     <= dy;
      button_bits_o <= header_btn_q;
      left_click_o  <= header_btn_q[LeftBit] && !held_q[LeftBit];
      right_click_o <= header_btn_q[RightBit] && !held_q[RightBit];
    end
  end

  assign res_valid_o = out_valid_q;

  `PMT_ASSERT_NOW(a_cursor_x_in_range, 1'b1, cursor_x_q <= XMax, "cursor x off screen")
  `PMT_ASSERT_NOW(a_cursor_y_in_range, 1'b1, cursor_y_q <= YMax, "cursor y off screen")
  `PMT_ASSERT_NEXT(a_held_only_on_packet, !(s1_fire && phase_q == PH_YMOVE), $stable(held_q),
                   "buttons changed without a full packet")
  `PMT_ASSERT_NOW(a_click_needs_button, res_valid_o && left_click_o, button_bits_o[LeftBit],
                  "left click without left button")

endmodule

`default_nettype wire
